FILE: rtl/pid_with_deadzone_separation_dfilter_unit_assert.svh
// assertion macros shared by the pid controller rtl
// no dependencies; included by the top level
`ifndef PID_WITH_DEADZONE_SEPARATION_DFILTER_UNIT_ASSERT_SVH
`define PID_WITH_DEADZONE_SEPARATION_DFILTER_UNIT_ASSERT_SVH

// same-cycle implication
`define PWD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwd assertion failed");

// next-cycle implication
`define PWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwd assertion failed");

`endif

FILE: rtl/pwd_pkg.sv
// types and constants of the pid controller
// no dependencies; used by pwd_mul and the top level
package pwd_pkg;

    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [3:0] CFG_GAIN_P    = 4'd0;
    localparam logic [3:0] CFG_GAIN_I    = 4'd1;
    localparam logic [3:0] CFG_GAIN_D    = 4'd2;
    localparam logic [3:0] CFG_OUT_LIM   = 4'd3;
    localparam logic [3:0] CFG_INT_LIM   = 4'd4;
    localparam logic [3:0] CFG_DEAD_BAND = 4'd5;
    localparam logic [3:0] CFG_SEP_THR   = 4'd6;
    localparam logic [3:0] CFG_FILT_COEF = 4'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_F1,
        ST_MUL_F2,
        ST_MUL_D,
        ST_SUM,
        ST_OUT
    } t_state;

endpackage

FILE: rtl/pid_with_deadzone_separation_dfilter_unit.sv
// top level of the pid controller with dead band, integral separation
// and filtered derivative; depends on pwd_pkg, pwd_mul and the assert header
//
// usage:
//   input channel i_in_valid / o_in_ready carries target, feedback, req_type.
//   output channel o_out_valid / i_out_ready carries drive and in_dead_band.
//   config channel i_cfg_valid / o_cfg_ready writes register i_cfg_index;
//   indexes beyond the list are ignored; always ready.
// sequencing and throughput:
//   clear and dead band items: idle, then the output state, then the output register.
//   compute items: five products in turn on one bit-serial 35x18 multiplier,
//   then the sum state and the output state; the filter coefficient at zero
//   skips two products.
//   one item at a time; the next item is accepted once the result has left the output state.
// reset:
//   clears controller state and loads register defaults.
// stall:
//   a result waits in the output register while i_out_ready is low; the
//   next item is accepted but its result waits until the register frees.
`include "pid_with_deadzone_separation_dfilter_unit_assert.svh"
module pid_with_deadzone_separation_dfilter_unit import pwd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_target,
    input  logic signed [15:0] i_feedback,
    input  logic               i_req_type,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_drive,
    output logic               o_in_dead_band,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_state r_state, n_state;

    logic signed [15:0] r_gain_p, r_gain_i, r_gain_d;
    logic [14:0]        r_out_lim, r_int_lim;
    logic [15:0]        r_dead_band, r_sep_thr, r_coef;

    logic signed [17:0] r_prev;
    logic signed [16:0] r_integ;
    logic signed [34:0] r_fd;

    logic signed [16:0] r_e;
    logic [16:0]        r_mag;
    logic signed [17:0] r_raw;
    logic signed [24:0] r_p;
    logic signed [35:0] r_t;
    logic signed [28:0] r_d;
    logic signed [15:0] r_res_drive;
    logic               r_res_db;
    logic               r_start, n_start;

    logic               r_out_valid;
    logic signed [15:0] r_out_drive;
    logic               r_out_db;

    logic signed [MUL_A_W-1:0] w_a;
    logic signed [MUL_B_W-1:0] w_b;
    logic                      w_done;
    logic signed [MUL_P_W-1:0] w_prod;

    logic               w_accept;
    logic signed [16:0] w_e;
    logic [16:0]        w_mag;
    logic               w_dead;
    logic signed [25:0] w_iacc;
    logic signed [16:0] w_iclamp;
    logic signed [29:0] w_sum;
    logic signed [15:0] w_sclamp;
    logic               w_out_free;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_e        = 17'(i_target) - 17'(i_feedback);
    assign w_mag      = w_e[16] ? 17'(-w_e) : w_e;
    assign w_dead     = w_mag < 17'(r_dead_band);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        w_iacc = 26'(r_integ) + 26'($signed(w_prod[32:8]));
        if (w_iacc > $signed(26'(r_int_lim))) begin
            w_iclamp = $signed(17'(r_int_lim));
        end else if (w_iacc < -$signed(26'(r_int_lim))) begin
            w_iclamp = -$signed(17'(r_int_lim));
        end else begin
            w_iclamp = 17'(w_iacc);
        end
        w_sum = 30'(r_p) + 30'(r_integ) + 30'(r_d);
        if (w_sum > $signed(30'(r_out_lim))) begin
            w_sclamp = $signed(16'(r_out_lim));
        end else if (w_sum < -$signed(30'(r_out_lim))) begin
            w_sclamp = -$signed(16'(r_out_lim));
        end else begin
            w_sclamp = 16'(w_sum);
        end
    end

    always_comb begin
        w_a = 35'(r_e);
        w_b = 18'(r_gain_p);
        unique case (r_state)
            ST_MUL_I:  w_b = 18'(r_gain_i);
            ST_MUL_F1: begin
                w_a = r_fd;
                w_b = $signed({2'b00, 16'(17'h10000 - 17'(r_coef))});
            end
            ST_MUL_F2: begin
                w_a = 35'(r_raw);
                w_b = $signed({2'b00, r_coef});
            end
            ST_MUL_D: begin
                w_a = r_fd;
                w_b = 18'(r_gain_d);
            end
            default: ;
        endcase
    end

    pwd_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_start),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_done (w_done),
        .o_prod (w_prod)
    );

    always_comb begin
        n_state = r_state;
        n_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_type || w_dead) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_MUL_P;
                        n_start = 1'b1;
                    end
                end
            end
            ST_MUL_P: begin
                if (w_done) begin
                    n_state = ST_MUL_I;
                    n_start = 1'b1;
                end
            end
            ST_MUL_I: begin
                if (w_done) begin
                    n_start = 1'b1;
                    n_state = (r_coef != 16'd0) ? ST_MUL_F1 : ST_MUL_D;
                end
            end
            ST_MUL_F1: begin
                if (w_done) begin
                    n_state = ST_MUL_F2;
                    n_start = 1'b1;
                end
            end
            ST_MUL_F2: begin
                if (w_done) begin
                    n_state = ST_MUL_D;
                    n_start = 1'b1;
                end
            end
            ST_MUL_D: begin
                if (w_done) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM:  n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_out_lim   <= 15'h7fff;
            r_int_lim   <= 15'h7fff;
            r_dead_band <= '0;
            r_sep_thr   <= '0;
            r_coef      <= 16'd19661;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAIN_P:    r_gain_p    <= i_cfg_data;
                CFG_GAIN_I:    r_gain_i    <= i_cfg_data;
                CFG_GAIN_D:    r_gain_d    <= i_cfg_data;
                CFG_OUT_LIM:   r_out_lim   <= i_cfg_data[14:0];
                CFG_INT_LIM:   r_int_lim   <= i_cfg_data[14:0];
                CFG_DEAD_BAND: r_dead_band <= i_cfg_data;
                CFG_SEP_THR:   r_sep_thr   <= i_cfg_data;
                CFG_FILT_COEF: r_coef      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_integ <= '0;
            r_fd    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_req_type) begin
                            r_prev  <= '0;
                            r_integ <= '0;
                            r_fd    <= '0;
                        end else if (w_dead) begin
                            r_prev  <= '0;
                            r_integ <= '0;
                        end
                    end
                end
                ST_MUL_I: begin
                    if (w_done) begin
                        if (r_sep_thr == 16'd0 || r_mag < 17'(r_sep_thr)) begin
                            r_integ <= w_iclamp;
                        end else begin
                            r_integ <= '0;
                        end
                        if (r_coef == 16'd0) begin
                            r_fd <= 35'($signed({r_raw, 16'd0}));
                        end
                    end
                end
                ST_MUL_F2: begin
                    if (w_done) begin
                        r_fd <= 35'(r_t + 36'(w_prod[35:0]));
                    end
                end
                ST_SUM:  r_prev <= 18'(r_e);
                default: ;
            endcase
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_accept) begin
            r_e         <= w_e;
            r_mag       <= w_mag;
            r_raw       <= 18'(w_e) - r_prev;
            r_res_drive <= '0;
            r_res_db    <= !i_req_type && w_dead;
        end
        if (r_state == ST_MUL_P && w_done) begin
            r_p <= w_prod[32:8];
        end
        if (r_state == ST_MUL_F1 && w_done) begin
            r_t <= w_prod[51:16];
        end
        if (r_state == ST_MUL_D && w_done) begin
            r_d <= w_prod[52:24];
        end
        if (r_state == ST_SUM) begin
            r_res_drive <= w_sclamp;
            r_res_db    <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            r_out_drive <= r_res_drive;
            r_out_db    <= r_res_db;
        end
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_drive        = r_out_drive;
    assign o_in_dead_band = r_out_db;

    `PWD_ASSERT_NOW(a_done_in_mul, i_clk, i_rst_n, w_done,
        r_state == ST_MUL_P || r_state == ST_MUL_I || r_state == ST_MUL_F1 ||
        r_state == ST_MUL_F2 || r_state == ST_MUL_D)
    `PWD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state != ST_IDLE)
    `PWD_ASSERT_NOW(a_db_zero, i_clk, i_rst_n, r_out_valid && r_out_db, r_out_drive == 16'sd0)
    `PWD_ASSERT_NEXT(a_start_once, i_clk, i_rst_n, r_start, !r_start)

endmodule

FILE: rtl/pwd_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
// depends on pwd_pkg
module pwd_mul import pwd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic                      o_done,
    output logic signed [MUL_P_W-1:0] o_prod
);

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic [4:0]                r_cnt, n_cnt;
    logic signed [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0]        r_b;
    logic [MUL_P_W-1:0]        r_acc;
    logic signed [MUL_A_W:0]   w_sum;
    logic                      w_last;

    assign w_last = (r_cnt == 5'(MUL_B_W - 1));

    always_comb begin
        w_sum = $signed(r_acc[MUL_P_W-1:MUL_B_W]);
        if (r_b[0]) begin
            if (w_last) begin
                w_sum = w_sum - (MUL_A_W+1)'(r_a);
            end else begin
                w_sum = w_sum + (MUL_A_W+1)'(r_a);
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 5'd1;
            if (w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= {1'b0, r_b[MUL_B_W-1:1]};
            r_acc <= {w_sum, r_acc[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = $signed(r_acc);

endmodule
